/* hw/rtl/pdi_pkg.sv */
`timescale 1ns / 1ps
package pdi_pkg;

  // Integral update period in samples.
  localparam int DOWNSAMPLE = 10;

  localparam int ERR_W   = 24;  // Q8.16 error fields
  localparam int GAIN_W  = 28;  // Q20.8 unsigned gains
  localparam int LIM_W   = 20;  // whole-unit limits
  localparam int CFG_W   = 28;  // widest register
  localparam int IDX_W   = 3;
  localparam int DRV_W   = 21;
  localparam int FRAC_W  = 24;  // fraction bits of products and integral
  localparam int SUM_W   = 28;  // error accumulator
  localparam int CNT_W   = 4;
  localparam int PROD_W  = 52;  // error times gain
  localparam int PD_W    = 53;  // proportional plus derivative
  localparam int INTEG_W = 45;
  localparam int TOT_W   = 54;

  // Division of the error sum by DOWNSAMPLE through a reciprocal. With
  // L = ceil(log2(DOWNSAMPLE)) and a ceiling reciprocal, the quotient is
  // exact for every magnitude below 2**SUM_W.
  localparam int DIV_L     = $clog2(DOWNSAMPLE);
  localparam int DIV_SHIFT = SUM_W + DIV_L;
  localparam longint unsigned DIV_RECIP_L =
    ((64'd1 << DIV_SHIFT) + 64'(DOWNSAMPLE) - 64'd1) / 64'(DOWNSAMPLE);
  localparam logic [SUM_W:0] DIV_RECIP = DIV_RECIP_L[SUM_W:0];

  localparam logic [CNT_W-1:0] DS_COUNT = CNT_W'(DOWNSAMPLE);

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [IDX_W-1:0] REG_INTEG_LIMIT = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUT_LIMIT   = 3'd4;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 28'd1024000;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 28'd256;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 28'd20480000;
  localparam logic [LIM_W-1:0]  INTEG_LIM_RST  = 20'd25200;
  localparam logic [LIM_W-1:0]  OUT_LIM_RST    = 20'd25200;

  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic [GAIN_W-1:0]         gain_t;
  typedef logic [LIM_W-1:0]          lim_t;
  typedef logic signed [DRV_W-1:0]   drive_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [PD_W-1:0]    pd_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [INTEG_W-1:0] integ_t;

  // Control that travels with an item down the pipeline.
  typedef struct packed {
    logic valid;
    logic upd;   // this item closes an integration period
  } pdi_ctl_t;

endpackage

/* hw/rtl/pdi_if.sv */
`timescale 1ns / 1ps
interface pdi_sample_if;
  import pdi_pkg::*;
  logic valid;
  logic ready;
  err_t prop_error;
  err_t deriv_error;
  modport source (output valid, prop_error, deriv_error, input ready);
  modport sink (input valid, prop_error, deriv_error, output ready);
endinterface

interface pdi_result_if;
  import pdi_pkg::*;
  logic   valid;
  logic   ready;
  drive_t drive;
  modport source (output valid, drive, input ready);
  modport sink (input valid, drive, output ready);
endinterface

/* hw/rtl/pdi_front.sv */
`timescale 1ns / 1ps
module pdi_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               valid1,
  input  pdi_pkg::err_t      pe1,
  input  pdi_pkg::err_t      de1,
  input  pdi_pkg::gain_t     prop_gain,
  input  pdi_pkg::gain_t     deriv_gain,
  output pdi_pkg::pdi_ctl_t  ctl2,
  output pdi_pkg::prod_t     p2,
  output pdi_pkg::prod_t     d2,
  output pdi_pkg::sum_t      sum2
);
  import pdi_pkg::*;

  sum_t             error_sum;
  logic [CNT_W-1:0] sample_count;
  sum_t             sum_inc;
  logic [CNT_W-1:0] cnt_inc;
  logic             upd;
  logic signed [PROD_W:0] p_full;
  logic signed [PROD_W:0] d_full;

  assign p_full  = pe1 * $signed({1'b0, prop_gain});
  assign d_full  = de1 * $signed({1'b0, deriv_gain});
  assign sum_inc = error_sum + SUM_W'(pe1);
  assign cnt_inc = sample_count + 1'b1;
  assign upd     = (cnt_inc >= DS_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum    <= '0;
      sample_count <= '0;
      ctl2         <= '0;
    end else if (adv) begin
      ctl2.valid <= valid1;
      ctl2.upd   <= upd;
      if (valid1) begin
        if (upd) begin
          error_sum    <= '0;
          sample_count <= '0;
        end else begin
          error_sum    <= sum_inc;
          sample_count <= cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2   <= $signed(p_full[PROD_W-1:0]);
      d2   <= $signed(d_full[PROD_W-1:0]);
      sum2 <= sum_inc;
    end
  end

endmodule

/* hw/rtl/pdi_integ.sv */
`timescale 1ns / 1ps
module pdi_integ (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  pdi_pkg::pdi_ctl_t  ctl2,
  input  pdi_pkg::prod_t     p2,
  input  pdi_pkg::prod_t     d2,
  input  pdi_pkg::sum_t      sum2,
  input  pdi_pkg::gain_t     integ_gain,
  input  pdi_pkg::lim_t      integ_limit,
  output logic               valid5,
  output pdi_pkg::pd_t       pd5,
  output pdi_pkg::integ_t    integ5
);
  import pdi_pkg::*;

  // Stage 3: average of the error sum, truncated toward zero.
  logic [SUM_W-1:0]        mag;
  logic [2*SUM_W:0]        q_full;
  logic [ERR_W-1:0]        q;
  err_t                    avg;
  pdi_ctl_t                ctl3;
  prod_t                   p3;
  prod_t                   d3;
  err_t                    avg3;

  // Stage 4: gain product and the sum of the other two terms.
  logic signed [PROD_W:0]  i_full;
  pdi_ctl_t                ctl4;
  prod_t                   prod4;
  pd_t                     pd4;

  // Stage 5 loop: integral update with clamp.
  integ_t                  integral;
  logic signed [PD_W-1:0]  isum;
  logic signed [PD_W-1:0]  ilim;
  logic signed [PD_W-1:0]  iclamp;
  integ_t                  integ_now;

  assign mag    = sum2[SUM_W-1] ? SUM_W'(-sum2) : SUM_W'(sum2);
  assign q_full = mag * DIV_RECIP;
  assign q      = q_full[DIV_SHIFT +: ERR_W];
  assign avg    = sum2[SUM_W-1] ? $signed(-q) : $signed(q);

  assign i_full = avg3 * $signed({1'b0, integ_gain});

  assign isum = PD_W'(integral) + PD_W'(prod4);
  assign ilim = $signed({{(PD_W-LIM_W-FRAC_W){1'b0}}, integ_limit, {FRAC_W{1'b0}}});

  always_comb begin
    if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = isum;
    end
  end

  assign integ_now = ctl4.upd ? $signed(iclamp[INTEG_W-1:0]) : integral;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3     <= '0;
      ctl4     <= '0;
      valid5   <= 1'b0;
      integral <= '0;
    end else if (adv) begin
      ctl3   <= ctl2;
      ctl4   <= ctl3;
      valid5 <= ctl4.valid;
      if (ctl4.valid && ctl4.upd) begin
        integral <= $signed(iclamp[INTEG_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3     <= p2;
      d3     <= d2;
      avg3   <= avg;
      prod4  <= $signed(i_full[PROD_W-1:0]);
      pd4    <= PD_W'(p3) + PD_W'(d3);
      pd5    <= pd4;
      integ5 <= integ_now;
    end
  end

endmodule

/* hw/rtl/pdi_out.sv */
`timescale 1ns / 1ps
module pdi_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             valid5,
  input  pdi_pkg::pd_t     pd5,
  input  pdi_pkg::integ_t  integ5,
  input  pdi_pkg::lim_t    out_limit,
  output logic             out_valid,
  output pdi_pkg::drive_t  drive
);
  import pdi_pkg::*;

  logic signed [TOT_W-1:0] total;
  logic signed [TOT_W-1:0] olim;
  logic signed [TOT_W-1:0] tclamp;

  assign total = TOT_W'(pd5) + TOT_W'(integ5);
  assign olim  = $signed({{(TOT_W-LIM_W-FRAC_W){1'b0}}, out_limit, {FRAC_W{1'b0}}});

  always_comb begin
    if (total > olim) begin
      tclamp = olim;
    end else if (total < -olim) begin
      tclamp = -olim;
    end else begin
      tclamp = total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= valid5;
    end
  end

  // Dropping the fraction bits of a two's complement value floors it.
  always_ff @(posedge clk) begin
    if (adv) begin
      drive <= $signed(tclamp[FRAC_W +: DRV_W]);
    end
  end

endmodule

/* hw/rtl/pid_downsampled_integral.sv */
`timescale 1ns / 1ps
// PID controller with an integral term that updates once per DOWNSAMPLE samples.
// The sample channel carries a proportional and a derivative error (signed
// Q8.16) per transaction; the result channel returns one drive transaction
// per sample, the clamped controller output floored to whole units.
// Gains and limits are written through the plain write port (wr_en, wr_index,
// wr_data); the user must write them only while no sample is in flight (the
// block does not enforce this); writes to indexes past the last are dropped.
// Throughput is one sample per cycle while the receiver does not stall;
// the rate is set by the integral register, whose add-and-clamp loop
// closes with no other register inside it.
// The pipeline runs input register, multipliers and error accumulator,
// reciprocal divide, integral gain multiply, integral update, then output
// sum, clamp and floor into the result register.
// When the receiver stalls, the whole pipeline holds and sample.ready drops
// in the same cycle; nothing is lost or repeated.
// Reset clears all valid flags, the error sum, the sample count and the
// integral, and loads the default gains and limits.
module pid_downsampled_integral (
  input  logic                         clk,
  input  logic                         rst,
  pdi_sample_if.sink                   sample,
  pdi_result_if.source                 result,
  input  logic                         wr_en,
  input  logic [pdi_pkg::IDX_W-1:0]    wr_index,
  input  logic [pdi_pkg::CFG_W-1:0]    wr_data
);
  import pdi_pkg::*;

  // Configuration registers.
  gain_t prop_gain;
  gain_t integ_gain;
  gain_t deriv_gain;
  lim_t  integ_limit;
  lim_t  out_limit;

  // Pipeline advance: every stage moves when the result register is free
  // or its transaction completes this cycle.
  logic     adv;
  logic     valid1;
  err_t     pe1;
  err_t     de1;
  pdi_ctl_t ctl2;
  prod_t    p2;
  prod_t    d2;
  sum_t     sum2;
  logic     valid5;
  pd_t      pd5;
  integ_t   integ5;

  assign adv          = !result.valid || result.ready;
  assign sample.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= PROP_GAIN_RST;
      integ_gain  <= INTEG_GAIN_RST;
      deriv_gain  <= DERIV_GAIN_RST;
      integ_limit <= INTEG_LIM_RST;
      out_limit   <= OUT_LIM_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_PROP_GAIN:   prop_gain   <= wr_data[GAIN_W-1:0];
        REG_INTEG_GAIN:  integ_gain  <= wr_data[GAIN_W-1:0];
        REG_DERIV_GAIN:  deriv_gain  <= wr_data[GAIN_W-1:0];
        REG_INTEG_LIMIT: integ_limit <= wr_data[LIM_W-1:0];
        REG_OUT_LIMIT:   out_limit   <= wr_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (adv) begin
      valid1 <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pe1 <= sample.prop_error;
      de1 <= sample.deriv_error;
    end
  end

  pdi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .valid1     (valid1),
    .pe1        (pe1),
    .de1        (de1),
    .prop_gain  (prop_gain),
    .deriv_gain (deriv_gain),
    .ctl2       (ctl2),
    .p2         (p2),
    .d2         (d2),
    .sum2       (sum2)
  );

  pdi_integ u_integ (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .ctl2        (ctl2),
    .p2          (p2),
    .d2          (d2),
    .sum2        (sum2),
    .integ_gain  (integ_gain),
    .integ_limit (integ_limit),
    .valid5      (valid5),
    .pd5         (pd5),
    .integ5      (integ5)
  );

  pdi_out u_out (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .valid5    (valid5),
    .pd5       (pd5),
    .integ5    (integ5),
    .out_limit (out_limit),
    .out_valid (result.valid),
    .drive     (result.drive)
  );

endmodule
